@@ rtl/core/mcmf_pkg.sv @@
// Shared constants, types and helpers of the min-cost max-flow block.
`timescale 1ns / 1ps
package mcmf_pkg;

  localparam int NODES     = 64;
  localparam int NODE_W    = 6;
  localparam int CELLS     = NODES * NODES;
  localparam int CELL_W    = 2 * NODE_W;
  localparam int CAP_W     = 16;
  localparam int FLOW_W    = 17;
  localparam int COST_W    = 32;
  localparam int ECOST_W   = 16;
  localparam int DIST_W    = 40;
  localparam int TOTAL_W   = 48;
  localparam int RESID_W   = 18;
  localparam int COUNT_W   = NODE_W + 1;
  localparam int POP_W     = CELL_W + 1;
  localparam int SWEEP_W   = CELL_W + 1;
  localparam int PROD_W    = RESID_W + 1 + COST_W;
  localparam logic [COST_W-1:0] COST_INIT = 32'd1000000000;
  localparam logic [POP_W-1:0]  POP_LIMIT = POP_W'(CELLS);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_SOLVE = 2'd2
  } opcode_t;

  typedef enum logic [4:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_ADD_RD1,
    ST_ADD_WR1,
    ST_ADD_RD2,
    ST_ADD_WR2,
    ST_SOLVE,
    ST_SR_START,
    ST_SR_POP,
    ST_SR_POPW,
    ST_SR_ROW,
    ST_SR_SCAN,
    ST_SR_EVAL,
    ST_P1_CHK,
    ST_P1_PAR,
    ST_P1_RES,
    ST_P2_CHK,
    ST_P2_PAR,
    ST_P2_FWD,
    ST_P2_REV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [CAP_W-1:0]         cap;
    logic signed [FLOW_W-1:0] flow;
    logic signed [COST_W-1:0] cost;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [1:0]                opcode;
    logic [NODE_W-1:0]         node_a;
    logic [NODE_W-1:0]         node_b;
    logic [CAP_W-1:0]          edge_capacity;
    logic signed [ECOST_W-1:0] edge_cost;
  } in_word_t;

  typedef struct packed {
    logic                       valid;
    logic signed [TOTAL_W-1:0]  total_cost;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [CELL_W-1:0] addr;
    entry_t            data;
  } graph_wr_t;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
    logic [NODES-1:0]  data;
  } adj_wr_t;

  typedef struct packed {
    logic                     en;
    logic [NODE_W-1:0]        addr;
    logic signed [DIST_W-1:0] data;
  } dist_wr_t;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
    logic [NODE_W-1:0] data;
  } node_wr_t;

  // Index of the lowest set bit.
  function automatic logic [NODE_W-1:0] lowest_bit(input logic [NODES-1:0] bits);
    logic [NODE_W-1:0] idx;
    idx = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (bits[i]) idx = NODE_W'(i);
    end
    return idx;
  endfunction

endpackage

@@ rtl/core/mcmf_if.sv @@
// Valid/ready channel interfaces for command words and results.
`timescale 1ns / 1ps
interface mcmf_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             opcode;
  logic [mcmf_pkg::NODE_W-1:0]            node_a;
  logic [mcmf_pkg::NODE_W-1:0]            node_b;
  logic [mcmf_pkg::CAP_W-1:0]             edge_capacity;
  logic signed [mcmf_pkg::ECOST_W-1:0]    edge_cost;
  modport source (output valid, opcode, node_a, node_b, edge_capacity, edge_cost,
                  input ready);
  modport sink (input valid, opcode, node_a, node_b, edge_capacity, edge_cost,
                output ready);
endinterface

interface mcmf_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mcmf_pkg::TOTAL_W-1:0]    total_cost;
  modport source (output valid, total_cost, input ready);
  modport sink (input valid, total_cost, output ready);
endinterface

@@ rtl/core/mcmf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mcmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/mcmf_core.sv @@
// Sequencer: graph edits, clearing sweep, queue search and path augmentation.
`timescale 1ns / 1ps
module mcmf_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  mcmf_pkg::in_word_t                    in_word,
  input  logic                                  out_busy,
  output mcmf_pkg::result_t                     res,
  output mcmf_pkg::graph_wr_t                   graph_wr,
  output logic [mcmf_pkg::CELL_W-1:0]           graph_raddr,
  input  mcmf_pkg::entry_t                      graph_rdata,
  output mcmf_pkg::adj_wr_t                     adj_wr,
  output logic [mcmf_pkg::NODE_W-1:0]           adj_raddr,
  input  logic [mcmf_pkg::NODES-1:0]            adj_rdata,
  output mcmf_pkg::dist_wr_t                    dist_wr,
  output logic [mcmf_pkg::NODE_W-1:0]           dist_raddr,
  input  logic signed [mcmf_pkg::DIST_W-1:0]    dist_rdata,
  output mcmf_pkg::node_wr_t                    pred_wr,
  output logic [mcmf_pkg::NODE_W-1:0]           pred_raddr,
  input  logic [mcmf_pkg::NODE_W-1:0]           pred_rdata,
  output mcmf_pkg::node_wr_t                    queue_wr,
  output logic [mcmf_pkg::NODE_W-1:0]           queue_raddr,
  input  logic [mcmf_pkg::NODE_W-1:0]           queue_rdata
);
  mcmf_pkg::state_t state, state_next;

  logic [mcmf_pkg::SWEEP_W-1:0]        sweep;
  logic [mcmf_pkg::NODE_W-1:0]         node_a, node_b;
  logic [mcmf_pkg::CAP_W-1:0]          cap_in;
  logic signed [mcmf_pkg::ECOST_W-1:0] cost_in;
  logic [mcmf_pkg::NODE_W-1:0]         cur, nxt, p, par;
  logic signed [mcmf_pkg::DIST_W-1:0]  dcur;
  logic [mcmf_pkg::NODES-1:0]          row_rem, reached, pred_ok, queued;
  logic [mcmf_pkg::NODE_W-1:0]         head;
  logic [mcmf_pkg::COUNT_W-1:0]        count;
  logic [mcmf_pkg::POP_W-1:0]          pops;
  logic [mcmf_pkg::COUNT_W-1:0]        steps;
  logic [mcmf_pkg::RESID_W-1:0]        bott;
  logic signed [mcmf_pkg::PROD_W-1:0]  prod;
  logic signed [mcmf_pkg::TOTAL_W-1:0] total;

  logic signed [mcmf_pkg::RESID_W-1:0] resid;
  logic                                resid_pos;
  logic signed [mcmf_pkg::DIST_W-1:0]  nc;
  logic                                improve, enqueue;
  logic [mcmf_pkg::NODE_W-1:0]         pick;
  logic signed [mcmf_pkg::RESID_W-1:0] flow_up, flow_dn;
  logic signed [mcmf_pkg::COST_W-1:0]  cost_w, cost_neg;

  assign resid     = $signed({2'b00, graph_rdata.cap}) - $signed({graph_rdata.flow[16],
                     graph_rdata.flow});
  assign resid_pos = !resid[mcmf_pkg::RESID_W-1] && (resid != '0);
  assign nc        = dcur + mcmf_pkg::DIST_W'(graph_rdata.cost);
  assign improve   = resid_pos && (!reached[nxt] || (nc < dist_rdata));
  assign enqueue   = improve && !queued[nxt] && (count < mcmf_pkg::COUNT_W'(mcmf_pkg::NODES));
  assign pick      = mcmf_pkg::lowest_bit(row_rem);
  assign flow_up   = $signed({graph_rdata.flow[16], graph_rdata.flow}) + $signed(bott);
  assign flow_dn   = $signed({graph_rdata.flow[16], graph_rdata.flow}) - $signed(bott);
  assign cost_w    = mcmf_pkg::COST_W'(cost_in);
  assign cost_neg  = -cost_w;

  always_ff @(posedge clk) begin
    if (rst) state <= mcmf_pkg::ST_SWEEP;
    else     state <= state_next;
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    res         = '0;
    graph_wr    = '0;
    graph_raddr = '0;
    adj_wr      = '0;
    adj_raddr   = '0;
    dist_wr     = '0;
    dist_raddr  = '0;
    pred_wr     = '0;
    pred_raddr  = '0;
    queue_wr    = '0;
    queue_raddr = '0;
    unique case (state)
      mcmf_pkg::ST_SWEEP: begin
        graph_wr.en        = 1'b1;
        graph_wr.addr      = sweep[mcmf_pkg::CELL_W-1:0];
        graph_wr.data.cap  = '0;
        graph_wr.data.flow = '0;
        graph_wr.data.cost = mcmf_pkg::COST_INIT;
        adj_wr.en   = (sweep < mcmf_pkg::SWEEP_W'(mcmf_pkg::NODES));
        adj_wr.addr = sweep[mcmf_pkg::NODE_W-1:0];
        adj_wr.data = '0;
        if (sweep == mcmf_pkg::SWEEP_W'(mcmf_pkg::CELLS - 1)) state_next = mcmf_pkg::ST_IDLE;
      end
      mcmf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_word.opcode)
            mcmf_pkg::OP_CLEAR: state_next = mcmf_pkg::ST_SWEEP;
            mcmf_pkg::OP_ADD:   state_next = mcmf_pkg::ST_ADD_RD1;
            mcmf_pkg::OP_SOLVE: state_next = mcmf_pkg::ST_SOLVE;
            default:            state_next = mcmf_pkg::ST_IDLE;
          endcase
        end
      end
      mcmf_pkg::ST_ADD_RD1: begin
        graph_raddr = {node_a, node_b};
        adj_raddr   = node_a;
        state_next  = mcmf_pkg::ST_ADD_WR1;
      end
      mcmf_pkg::ST_ADD_WR1: begin
        graph_wr.en        = 1'b1;
        graph_wr.addr      = {node_a, node_b};
        graph_wr.data      = graph_rdata;
        graph_wr.data.cap  = cap_in;
        graph_wr.data.cost = cost_w;
        adj_wr.en          = 1'b1;
        adj_wr.addr        = node_a;
        adj_wr.data        = adj_rdata | (mcmf_pkg::NODES'(1) << node_b);
        state_next         = mcmf_pkg::ST_ADD_RD2;
      end
      mcmf_pkg::ST_ADD_RD2: begin
        graph_raddr = {node_b, node_a};
        adj_raddr   = node_b;
        state_next  = mcmf_pkg::ST_ADD_WR2;
      end
      mcmf_pkg::ST_ADD_WR2: begin
        graph_wr.en        = 1'b1;
        graph_wr.addr      = {node_b, node_a};
        graph_wr.data      = graph_rdata;
        graph_wr.data.cost = cost_neg;
        adj_wr.en          = 1'b1;
        adj_wr.addr        = node_b;
        adj_wr.data        = adj_rdata | (mcmf_pkg::NODES'(1) << node_a);
        state_next         = mcmf_pkg::ST_IDLE;
      end
      mcmf_pkg::ST_SOLVE: begin
        if (node_a == node_b) state_next = mcmf_pkg::ST_DONE;
        else                  state_next = mcmf_pkg::ST_SR_START;
      end
      mcmf_pkg::ST_SR_START: begin
        dist_wr.en    = 1'b1;
        dist_wr.addr  = node_a;
        dist_wr.data  = '0;
        queue_wr.en   = 1'b1;
        queue_wr.addr = '0;
        queue_wr.data = node_a;
        state_next    = mcmf_pkg::ST_SR_POP;
      end
      mcmf_pkg::ST_SR_POP: begin
        queue_raddr = head;
        if (count == '0) begin
          state_next = pred_ok[node_b] ? mcmf_pkg::ST_P1_CHK : mcmf_pkg::ST_DONE;
        end else if (pops >= mcmf_pkg::POP_LIMIT) begin
          state_next = mcmf_pkg::ST_DONE;
        end else begin
          state_next = mcmf_pkg::ST_SR_POPW;
        end
      end
      mcmf_pkg::ST_SR_POPW: begin
        adj_raddr  = queue_rdata;
        dist_raddr = queue_rdata;
        state_next = mcmf_pkg::ST_SR_ROW;
      end
      mcmf_pkg::ST_SR_ROW: state_next = mcmf_pkg::ST_SR_SCAN;
      mcmf_pkg::ST_SR_SCAN: begin
        graph_raddr = {cur, pick};
        dist_raddr  = pick;
        if (row_rem == '0) state_next = mcmf_pkg::ST_SR_POP;
        else               state_next = mcmf_pkg::ST_SR_EVAL;
      end
      mcmf_pkg::ST_SR_EVAL: begin
        dist_wr.en    = improve;
        dist_wr.addr  = nxt;
        dist_wr.data  = nc;
        pred_wr.en    = improve;
        pred_wr.addr  = nxt;
        pred_wr.data  = cur;
        queue_wr.en   = enqueue;
        queue_wr.addr = head + count[mcmf_pkg::NODE_W-1:0];
        queue_wr.data = nxt;
        state_next    = mcmf_pkg::ST_SR_SCAN;
      end
      mcmf_pkg::ST_P1_CHK: begin
        pred_raddr = p;
        if (p == node_a) state_next = mcmf_pkg::ST_P2_CHK;
        else if (!pred_ok[p] || steps >= mcmf_pkg::COUNT_W'(mcmf_pkg::NODES))
          state_next = mcmf_pkg::ST_DONE;
        else state_next = mcmf_pkg::ST_P1_PAR;
      end
      mcmf_pkg::ST_P1_PAR: begin
        graph_raddr = {pred_rdata, p};
        state_next  = mcmf_pkg::ST_P1_RES;
      end
      mcmf_pkg::ST_P1_RES: state_next = mcmf_pkg::ST_P1_CHK;
      mcmf_pkg::ST_P2_CHK: begin
        pred_raddr = p;
        if (p == node_a) state_next = mcmf_pkg::ST_SR_START;
        else             state_next = mcmf_pkg::ST_P2_PAR;
      end
      mcmf_pkg::ST_P2_PAR: begin
        graph_raddr = {pred_rdata, p};
        state_next  = mcmf_pkg::ST_P2_FWD;
      end
      mcmf_pkg::ST_P2_FWD: begin
        graph_wr.en        = 1'b1;
        graph_wr.addr      = {par, p};
        graph_wr.data      = graph_rdata;
        graph_wr.data.flow = flow_up[mcmf_pkg::FLOW_W-1:0];
        graph_raddr        = {p, par};
        state_next         = mcmf_pkg::ST_P2_REV;
      end
      mcmf_pkg::ST_P2_REV: begin
        graph_wr.en        = 1'b1;
        graph_wr.addr      = {p, par};
        graph_wr.data      = graph_rdata;
        graph_wr.data.flow = flow_dn[mcmf_pkg::FLOW_W-1:0];
        state_next         = mcmf_pkg::ST_P2_CHK;
      end
      mcmf_pkg::ST_DONE: begin
        // hold the result until the output word has gone
        if (!out_busy) begin
          res.valid      = 1'b1;
          res.total_cost = total;
          state_next     = mcmf_pkg::ST_IDLE;
        end
      end
      default: state_next = mcmf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep   <= '0;
      reached <= '0;
      pred_ok <= '0;
      queued  <= '0;
      head    <= '0;
      count   <= '0;
      pops    <= '0;
    end else begin
      case (state)
        mcmf_pkg::ST_SWEEP: sweep <= sweep + 1'b1;
        mcmf_pkg::ST_IDLE: begin
          sweep   <= '0;
          node_a  <= in_word.node_a;
          node_b  <= in_word.node_b;
          cap_in  <= in_word.edge_capacity;
          cost_in <= in_word.edge_cost;
          total   <= '0;
        end
        mcmf_pkg::ST_SR_START: begin
          reached <= mcmf_pkg::NODES'(1) << node_a;
          queued  <= mcmf_pkg::NODES'(1) << node_a;
          pred_ok <= '0;
          head    <= '0;
          count   <= mcmf_pkg::COUNT_W'(1);
          pops    <= '0;
        end
        mcmf_pkg::ST_SR_POP: begin
          if (count != '0 && pops < mcmf_pkg::POP_LIMIT) begin
            pops  <= pops + 1'b1;
            head  <= head + 1'b1;
            count <= count - 1'b1;
          end
          p     <= node_b;
          steps <= '0;
          bott  <= '1;
        end
        mcmf_pkg::ST_SR_POPW: begin
          cur                 <= queue_rdata;
          queued[queue_rdata] <= 1'b0;
        end
        mcmf_pkg::ST_SR_ROW: begin
          row_rem <= adj_rdata;
          dcur    <= dist_rdata;
        end
        mcmf_pkg::ST_SR_SCAN: begin
          nxt           <= pick;
          row_rem[pick] <= 1'b0;
        end
        mcmf_pkg::ST_SR_EVAL: begin
          if (improve) begin
            reached[nxt] <= 1'b1;
            pred_ok[nxt] <= 1'b1;
            // a self loop lowers the label of the node being expanded
            if (nxt == cur) dcur <= nc;
          end
          if (enqueue) begin
            count       <= count + 1'b1;
            queued[nxt] <= 1'b1;
          end
        end
        mcmf_pkg::ST_P1_PAR: begin
          p     <= pred_rdata;
          steps <= steps + 1'b1;
        end
        mcmf_pkg::ST_P1_RES: begin
          if ($unsigned(resid) < bott) bott <= resid;
        end
        mcmf_pkg::ST_P1_CHK: begin
          if (p == node_a) p <= node_b;
        end
        mcmf_pkg::ST_P2_PAR: par <= pred_rdata;
        mcmf_pkg::ST_P2_FWD: prod <= $signed({1'b0, bott}) * graph_rdata.cost;
        mcmf_pkg::ST_P2_REV: begin
          total <= total + prod[mcmf_pkg::TOTAL_W-1:0];
          p     <= par;
        end
        default: ;
      endcase
    end
  end
endmodule

@@ rtl/core/min_cost_max_flow_top.sv @@
// Top level of the min-cost max-flow block: memories, sequencer, result register.
//
//   channel  role   payload
//   in_ch    sink   opcode, node_a, node_b, edge_capacity, edge_cost
//   out_ch   source total_cost (one word per solve)
//
// Clear sweeps every graph cell; add edge reads then writes the forward cell, then the
// reverse cell. A solve scans each popped node's neighbours (scan, then evaluate), then
// walks the path twice per augment: first for the bottleneck, then for the flow update.
// Reset starts a clearing pass of the graph memory; no word is taken
// until it ends. A finished result waits in the output register while the next
// command word is taken; a solve stalls at its end until that register is free.
`timescale 1ns / 1ps
module min_cost_max_flow_top (
  input logic       clk,
  input logic       rst,
  mcmf_in_if.sink   in_ch,
  mcmf_out_if.source out_ch
);
  mcmf_pkg::in_word_t  in_word;
  mcmf_pkg::result_t   res;
  mcmf_pkg::graph_wr_t graph_wr;
  mcmf_pkg::adj_wr_t   adj_wr;
  mcmf_pkg::dist_wr_t  dist_wr;
  mcmf_pkg::node_wr_t  pred_wr, queue_wr;
  mcmf_pkg::entry_t    graph_rdata;
  logic [mcmf_pkg::ENTRY_W-1:0]       graph_rbits;
  logic [mcmf_pkg::CELL_W-1:0]        graph_raddr;
  logic [mcmf_pkg::NODE_W-1:0]        adj_raddr, dist_raddr, pred_raddr, queue_raddr;
  logic [mcmf_pkg::NODES-1:0]         adj_rdata;
  logic signed [mcmf_pkg::DIST_W-1:0] dist_rdata;
  logic [mcmf_pkg::DIST_W-1:0]        dist_rbits;
  logic [mcmf_pkg::NODE_W-1:0]        pred_rdata, queue_rdata;
  logic                               in_ready;

  assign in_word.opcode        = in_ch.opcode;
  assign in_word.node_a        = in_ch.node_a;
  assign in_word.node_b        = in_ch.node_b;
  assign in_word.edge_capacity = in_ch.edge_capacity;
  assign in_word.edge_cost     = in_ch.edge_cost;
  assign in_ch.ready           = in_ready;
  assign graph_rdata           = graph_rbits;
  assign dist_rdata            = $signed(dist_rbits);

  mcmf_ram #(.WIDTH(mcmf_pkg::ENTRY_W), .DEPTH(mcmf_pkg::CELLS)) u_graph (
    .clk(clk), .we(graph_wr.en), .waddr(graph_wr.addr), .wdata(graph_wr.data),
    .raddr(graph_raddr), .rdata(graph_rbits)
  );
  mcmf_ram #(.WIDTH(mcmf_pkg::NODES), .DEPTH(mcmf_pkg::NODES)) u_adj (
    .clk(clk), .we(adj_wr.en), .waddr(adj_wr.addr), .wdata(adj_wr.data),
    .raddr(adj_raddr), .rdata(adj_rdata)
  );
  mcmf_ram #(.WIDTH(mcmf_pkg::DIST_W), .DEPTH(mcmf_pkg::NODES)) u_dist (
    .clk(clk), .we(dist_wr.en), .waddr(dist_wr.addr), .wdata(dist_wr.data),
    .raddr(dist_raddr), .rdata(dist_rbits)
  );
  mcmf_ram #(.WIDTH(mcmf_pkg::NODE_W), .DEPTH(mcmf_pkg::NODES)) u_pred (
    .clk(clk), .we(pred_wr.en), .waddr(pred_wr.addr), .wdata(pred_wr.data),
    .raddr(pred_raddr), .rdata(pred_rdata)
  );
  mcmf_ram #(.WIDTH(mcmf_pkg::NODE_W), .DEPTH(mcmf_pkg::NODES)) u_queue (
    .clk(clk), .we(queue_wr.en), .waddr(queue_wr.addr), .wdata(queue_wr.data),
    .raddr(queue_raddr), .rdata(queue_rdata)
  );

  mcmf_core u_core (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ready), .in_word(in_word),
    .out_busy(out_ch.valid), .res(res),
    .graph_wr(graph_wr), .graph_raddr(graph_raddr), .graph_rdata(graph_rdata),
    .adj_wr(adj_wr), .adj_raddr(adj_raddr), .adj_rdata(adj_rdata),
    .dist_wr(dist_wr), .dist_raddr(dist_raddr), .dist_rdata(dist_rdata),
    .pred_wr(pred_wr), .pred_raddr(pred_raddr), .pred_rdata(pred_rdata),
    .queue_wr(queue_wr), .queue_raddr(queue_raddr), .queue_rdata(queue_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (res.valid) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) out_ch.total_cost <= res.total_cost;
  end
endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the min-cost max-flow block.
`timescale 1ns / 1ps
module tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 20_000_000;
  localparam int HOLD_CYCLES = 6000;
  localparam int DRAIN_CYCLES = 5000;
  localparam int NODES = mcmf_pkg::NODES;
  localparam int CELLS = mcmf_pkg::CELLS;
  localparam int TOTAL_W = mcmf_pkg::TOTAL_W;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mcmf_in_if in_ch ();
  mcmf_out_if out_ch ();

  min_cost_max_flow_top DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the graph and search scratch.
  logic [mcmf_pkg::CAP_W-1:0] cap_mem[CELLS];
  int flow_mem[CELLS];
  int cost_mem[CELLS];
  logic [NODES-1:0] adj_row[NODES];
  longint dist_lbl[NODES];
  bit reached[NODES];
  int parent[NODES];
  bit parent_ok[NODES];
  bit in_fifo[NODES];
  int node_fifo[NODES];

  logic [TOTAL_W-1:0] cost_q[$];
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_go = 1'b0;
  bit hold_on = 1'b0;
  bit need_clear = 1'b0;
  int errors = 0;
  int n_items = 0;
  int n_solve = 0;
  int n_clear = 0;
  int n_results = 0;
  int n_neg = 0;
  longint cycles = 0;

  function automatic void wipe_graph();
    for (int i = 0; i < CELLS; i++) begin
      cap_mem[i] = '0;
      flow_mem[i] = 0;
      cost_mem[i] = int'(mcmf_pkg::COST_INIT);
    end
    for (int i = 0; i < NODES; i++) adj_row[i] = '0;
  endfunction

  // FIFO label-correcting shortest path; returns 0 when the pop bound trips.
  function automatic bit find_path(int src);
    int head, count, cur, nxt, idx;
    longint pops, resid, nc;
    head = 0;
    pops = 0;
    for (int i = 0; i < NODES; i++) begin
      reached[i] = 0;
      parent_ok[i] = 0;
      in_fifo[i] = 0;
    end
    reached[src] = 1;
    dist_lbl[src] = 0;
    node_fifo[0] = src;
    in_fifo[src] = 1;
    count = 1;
    while (count > 0) begin
      if (pops >= CELLS) return 0;
      pops++;
      cur = node_fifo[head];
      head = (head + 1) % NODES;
      count--;
      in_fifo[cur] = 0;
      for (nxt = 0; nxt < NODES; nxt++) begin
        if (!adj_row[cur][nxt]) continue;
        idx = cur * NODES + nxt;
        resid = longint'(cap_mem[idx]) - longint'(flow_mem[idx]);
        if (resid <= 0) continue;
        nc = dist_lbl[cur] + longint'(cost_mem[idx]);
        if (reached[nxt] && nc >= dist_lbl[nxt]) continue;
        dist_lbl[nxt] = nc;
        reached[nxt] = 1;
        parent[nxt] = cur;
        parent_ok[nxt] = 1;
        if (!in_fifo[nxt] && count < NODES) begin
          node_fifo[(head + count) % NODES] = nxt;
          count++;
          in_fifo[nxt] = 1;
        end
      end
    end
    return 1;
  endfunction

  function automatic logic [TOTAL_W-1:0] flow_cost(int src, int dst, output bit tripped);
    logic [63:0] total;
    int p, par, steps, idx;
    longint bott, resid;
    total = '0;
    tripped = 0;
    if (src == dst) return '0;
    while (1) begin
      if (!find_path(src)) begin
        tripped = 1;
        break;
      end
      if (!parent_ok[dst]) break;
      bott = longint'(mcmf_pkg::COST_INIT);
      p = dst;
      steps = 0;
      while (p != src) begin
        if (!parent_ok[p] || steps >= NODES) return total[TOTAL_W-1:0];
        par = parent[p];
        idx = par * NODES + p;
        resid = longint'(cap_mem[idx]) - longint'(flow_mem[idx]);
        if (resid < bott) bott = resid;
        p = par;
        steps++;
      end
      p = dst;
      while (p != src) begin
        par = parent[p];
        idx = par * NODES + p;
        flow_mem[idx] += int'(bott);
        flow_mem[p * NODES + par] -= int'(bott);
        total += 64'(bott * longint'(cost_mem[idx]));
        p = par;
      end
    end
    return total[TOTAL_W-1:0];
  endfunction

  // Update the shadow state for one accepted word; queue its result, if any.
  function automatic void apply_word(mcmf_pkg::in_word_t w, bit fixed,
                                     logic [TOTAL_W-1:0] fixed_val);
    logic [TOTAL_W-1:0] res;
    bit tripped;
    int a, b;
    a = int'(w.node_a);
    b = int'(w.node_b);
    case (w.opcode)
      mcmf_pkg::OP_CLEAR: begin
        wipe_graph();
        n_clear++;
      end
      mcmf_pkg::OP_ADD: begin
        adj_row[a][b] = 1'b1;
        adj_row[b][a] = 1'b1;
        cap_mem[a * NODES + b] = w.edge_capacity;
        cost_mem[a * NODES + b] = int'(w.edge_cost);
        cost_mem[b * NODES + a] = -int'(w.edge_cost);
      end
      mcmf_pkg::OP_SOLVE: begin
        res = flow_cost(a, b, tripped);
        if (tripped) begin
          need_clear = 1'b1;
          n_neg++;
        end
        cost_q = {cost_q, (fixed ? fixed_val : res)};
        n_solve++;
      end
      default: ;
    endcase
  endfunction

  task automatic send_word(mcmf_pkg::in_word_t w, bit fixed = 0,
                           logic [TOTAL_W-1:0] fixed_val = '0);
    int gap;
    gap = 0;
    while (send_idle > 0 && $urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= w.opcode;
    in_ch.node_a <= w.node_a;
    in_ch.node_b <= w.node_b;
    in_ch.edge_capacity <= w.edge_capacity;
    in_ch.edge_cost <= w.edge_cost;
    do @(posedge clk); while (!in_ch.ready);
    apply_word(w, fixed, fixed_val);
    if (w.opcode != OP_UNUSED) n_items++;
  endtask

  function automatic mcmf_pkg::in_word_t mk(logic [1:0] op, int a, int b, int cap, int cst);
    mcmf_pkg::in_word_t w;
    w.opcode = op;
    w.node_a = mcmf_pkg::NODE_W'(a);
    w.node_b = mcmf_pkg::NODE_W'(b);
    w.edge_capacity = mcmf_pkg::CAP_W'(cap);
    w.edge_cost = mcmf_pkg::ECOST_W'(cst);
    return w;
  endfunction

  typedef struct {
    mcmf_pkg::in_word_t w;
    bit fixed;
    logic [TOTAL_W-1:0] val;
  } row_t;

  row_t plan[$];

  task automatic add_row(logic [1:0] op, int a, int b, int cap, int cst,
                         bit fixed = 0, longint val = 0);
    row_t r;
    r.w = mk(op, a, b, cap, cst);
    r.fixed = fixed;
    r.val = TOTAL_W'(val);
    plan = {plan, r};
  endtask

  task automatic random_words(int n);
    int done, span, lo, r, a, b, cap, cst;
    bit neg_set;
    done = 0;
    span = 7;
    lo = 0;
    neg_set = 0;
    while (done < n) begin
      r = $urandom_range(99);
      if (need_clear || r < 2) begin
        need_clear = 0;
        span = ($urandom_range(9) == 0) ? 63 : 7;
        lo = (span == 63) ? 0 : $urandom_range(0, 63 - 7);
        neg_set = ($urandom_range(9) == 0);
        send_word(mk(mcmf_pkg::OP_CLEAR, $urandom_range(63), $urandom_range(63),
                     $urandom(), $urandom()));
        done++;
      end else if (r < 4) begin
        // ignored word: does not count
        send_word(mk(OP_UNUSED, $urandom_range(63), $urandom_range(63), $urandom(),
                     $urandom()));
      end else begin
        a = lo + $urandom_range(span);
        b = lo + $urandom_range(span);
        if (r < 30) begin
          send_word(mk(mcmf_pkg::OP_SOLVE, a, b, $urandom(), $urandom()));
        end else begin
          cap = ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(65535);
          cst = (neg_set && $urandom_range(6) == 0) ? -$urandom_range(1, 32768)
                                                    : $urandom_range(32767);
          send_word(mk(mcmf_pkg::OP_ADD, a, b, cap, cst));
        end
        done++;
      end
    end
  endtask

  task automatic drain();
    while (cost_q.size() > 0) @(posedge clk);
  endtask

  // Receiver: random stall plus the long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_on && ($urandom_range(99) >= recv_stall);
    end
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on = 1'b0;
  end

  // Compare each result word against the oldest expectation.
  always @(posedge clk) begin
    logic [TOTAL_W-1:0] want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (cost_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result total_cost=%0d", out_ch.total_cost);
      end else begin
        want = cost_q.pop_front();
        if (out_ch.total_cost !== want) begin
          errors++;
          if (errors <= 10)
            $display("total_cost mismatch: expected %0d got %0d",
                     $signed(want), out_ch.total_cost);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, cost_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = mcmf_pkg::OP_CLEAR;
    in_ch.node_a = '0;
    in_ch.node_b = '0;
    in_ch.edge_capacity = '0;
    in_ch.edge_cost = '0;
    wipe_graph();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty graph, source equals sink
    add_row(mcmf_pkg::OP_SOLVE, 0, 1, 0, 0, 1, 0);
    add_row(mcmf_pkg::OP_SOLVE, 5, 5, 0, 0, 1, 0);
    add_row(mcmf_pkg::OP_ADD, 0, 1, 65535, 32767);
    add_row(mcmf_pkg::OP_ADD, 1, 2, 10, -32768);
    add_row(mcmf_pkg::OP_SOLVE, 0, 2, 0, 0, 1, -10);
    // repeated solve continues from saturated flow
    add_row(mcmf_pkg::OP_SOLVE, 0, 2, 0, 0, 1, 0);
    // self loop keeps the negated cost
    add_row(mcmf_pkg::OP_ADD, 3, 3, 5, -7);
    add_row(mcmf_pkg::OP_SOLVE, 3, 4, 0, 0, 1, 0);
    // opposite edges share cost entries
    add_row(mcmf_pkg::OP_ADD, 4, 5, 3, 2);
    add_row(mcmf_pkg::OP_ADD, 5, 4, 3, 9);
    add_row(mcmf_pkg::OP_SOLVE, 4, 5, 0, 0);
    add_row(OP_UNUSED, 63, 63, 65535, -1);
    add_row(mcmf_pkg::OP_ADD, 62, 63, 0, 0);
    add_row(mcmf_pkg::OP_ADD, 63, 0, 40000, 100);
    add_row(mcmf_pkg::OP_SOLVE, 63, 2, 0, 0);
    add_row(mcmf_pkg::OP_SOLVE, 63, 62, 0, 0, 1, 0);
    // negative cycle hits the pop bound
    add_row(mcmf_pkg::OP_ADD, 10, 11, 100, -5);
    add_row(mcmf_pkg::OP_ADD, 11, 12, 100, -5);
    add_row(mcmf_pkg::OP_ADD, 12, 10, 100, -5);
    add_row(mcmf_pkg::OP_SOLVE, 10, 12, 0, 0);
    add_row(mcmf_pkg::OP_CLEAR, 0, 0, 0, 0);
    add_row(mcmf_pkg::OP_SOLVE, 10, 12, 0, 0, 1, 0);
    foreach (plan[i]) send_word(plan[i].w, plan[i].fixed, plan[i].val);
    need_clear = 0;

    random_words(190);
    send_idle = 82;
    random_words(190);
    send_idle = 0;
    recv_stall = 82;
    random_words(190);
    send_idle = 26;
    recv_stall = 26;
    random_words(190);
    // long receiver hold-off while words keep coming
    send_idle = 0;
    recv_stall = 0;
    hold_go = 1'b1;
    random_words(190);

    in_ch.valid <= 1'b0;
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d words: %0d solves, %0d clears, %0d pop-bound solves",
             n_items, n_solve, n_clear, n_neg);
    $display("%0d results checked, %0d mismatches, %0d cycles", n_results, errors, cycles);
    if (errors == 0 && cost_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
